// ----- sv/uetc_pkg.sv -----
package uetc_pkg;

   localparam int UNIT_W = 16;

   // one input beat as held in the input register
   typedef struct packed {
      logic [UNIT_W-1:0] code_unit;
      logic              last_unit;
   } unit_beat_type;

   // result flags of one string
   typedef struct packed {
      logic has_emoji;
      logic emoji_only;
   } flags_type;

   // handshake between the input stage, the scanner and the result stage
   typedef struct packed {
      logic consume;   // the held beat is taken into the scan state this cycle
      logic load;      // the held beat is the last one and its result is loaded
   } step_ctl_type;

endpackage

// ----- sv/uetc_in_stage.sv -----
module uetc_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            req_tdata,    // [15:0] code_unit
   input  logic                   req_tlast,    // last_unit
   input  logic                   rsp_free,
   output uetc_pkg::unit_beat_type beat,
   output uetc_pkg::step_ctl_type  ctl
);
   import uetc_pkg::*;

   logic          valid_ff, valid_in;
   unit_beat_type beat_ff,  beat_in;
   logic          accept;

   // a beat that ends a string waits until the result register can take it
   always_comb begin
      ctl.consume = valid_ff && (!beat_ff.last_unit || rsp_free);
      ctl.load    = ctl.consume && beat_ff.last_unit;
   end

   assign req_tready = !valid_ff || ctl.consume;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (accept) begin
         valid_in          = 1'b1;
         beat_in.code_unit = req_tdata;
         beat_in.last_unit = req_tlast;
      end else if (ctl.consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign beat = beat_ff;

endmodule

// ----- sv/uetc_scan.sv -----
module uetc_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  uetc_pkg::unit_beat_type beat,
   input  uetc_pkg::step_ctl_type  ctl,
   output uetc_pkg::flags_type     flags
);
   import uetc_pkg::*;

   localparam logic [20:0] SUPP_BASE  = 21'h10000;
   localparam logic [5:0]  LEAD_TAG   = 6'b110110;
   localparam logic [5:0]  TRAIL_TAG  = 6'b110111;

   function automatic logic in_emoji_range(input logic [20:0] cp);
      in_emoji_range = (cp >= 21'h1F300 && cp <= 21'h1F5FF)
                    || (cp >= 21'h1F600 && cp <= 21'h1F64F)
                    || (cp >= 21'h1F680 && cp <= 21'h1F6FF)
                    || (cp >= 21'h1F900 && cp <= 21'h1F9FF)
                    || (cp >= 21'h1FA70 && cp <= 21'h1FAFF)
                    || (cp >= 21'h02600 && cp <= 21'h027BF)
                    || (cp >= 21'h1F1E6 && cp <= 21'h1F1FF);
   endfunction

   // variation selectors, zero width joiner and skin-tone modifiers
   function automatic logic is_ignorable(input logic [20:0] cp);
      is_ignorable = (cp == 21'h0FE0F) || (cp == 21'h0FE0E) || (cp == 21'h0200D)
                  || (cp >= 21'h1F3FB && cp <= 21'h1F3FF);
   endfunction

   logic       lead_pending_ff, lead_pending_in;
   logic [9:0] held_lead_ff,    held_lead_in;
   logic       any_emoji_ff,    any_emoji_in;
   logic       counted_ff,      counted_in;
   logic       other_ff,        other_in;
   logic       stopped_ff,      stopped_in;

   logic        is_lead, is_trail, pair, hold_new, flush_lead, take;
   logic        cp_zero, cp_emoji, cp_ign;
   logic [20:0] cp;
   logic        any_nx, counted_nx, other_nx, stopped_nx, pending_nx;
   logic [9:0]  held_nx;

   // surrogate pairing
   always_comb begin
      is_lead    = beat.code_unit[15:10] == LEAD_TAG;
      is_trail   = beat.code_unit[15:10] == TRAIL_TAG;
      pair       = lead_pending_ff && is_trail;
      hold_new   = !pair && is_lead && !beat.last_unit;
      flush_lead = !stopped_ff && lead_pending_ff && !pair;
      take       = !stopped_ff && !hold_new;
      cp         = pair ? SUPP_BASE + {1'b0, held_lead_ff, beat.code_unit[9:0]}
                        : {5'd0, beat.code_unit};
   end

   // classification and flag update; a flushed lone lead is never emoji
   always_comb begin
      cp_zero    = cp == 21'd0;
      cp_emoji   = in_emoji_range(cp);
      cp_ign     = is_ignorable(cp);
      any_nx     = any_emoji_ff || (take && !cp_zero && cp_emoji);
      counted_nx = counted_ff || (take && !cp_zero && cp_emoji && !cp_ign);
      other_nx   = other_ff || flush_lead || (take && !cp_zero && !cp_emoji && !cp_ign);
      stopped_nx = stopped_ff || (take && cp_zero);
      pending_nx = stopped_ff ? lead_pending_ff : hold_new;
      held_nx    = (!stopped_ff && hold_new) ? beat.code_unit[9:0] : held_lead_ff;
   end

   assign flags.has_emoji  = any_nx;
   assign flags.emoji_only = counted_nx && !other_nx;

   // state returns to its reset value after the last beat of a string
   always_comb begin
      lead_pending_in = lead_pending_ff;
      held_lead_in    = held_lead_ff;
      any_emoji_in    = any_emoji_ff;
      counted_in      = counted_ff;
      other_in        = other_ff;
      stopped_in      = stopped_ff;
      if (ctl.load) begin
         lead_pending_in = 1'b0;
         held_lead_in    = 10'd0;
         any_emoji_in    = 1'b0;
         counted_in      = 1'b0;
         other_in        = 1'b0;
         stopped_in      = 1'b0;
      end else if (ctl.consume) begin
         lead_pending_in = pending_nx;
         held_lead_in    = held_nx;
         any_emoji_in    = any_nx;
         counted_in      = counted_nx;
         other_in        = other_nx;
         stopped_in      = stopped_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_pending_ff <= 1'b0;
         held_lead_ff    <= 10'd0;
         any_emoji_ff    <= 1'b0;
         counted_ff      <= 1'b0;
         other_ff        <= 1'b0;
         stopped_ff      <= 1'b0;
      end else begin
         lead_pending_ff <= lead_pending_in;
         held_lead_ff    <= held_lead_in;
         any_emoji_ff    <= any_emoji_in;
         counted_ff      <= counted_in;
         other_ff        <= other_in;
         stopped_ff      <= stopped_in;
      end
   end

endmodule

// ----- sv/uetc_out_stage.sv -----
module uetc_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  uetc_pkg::step_ctl_type ctl,
   input  uetc_pkg::flags_type    flags,
   output logic                   rsp_free,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata    // [0] has_emoji, [1] emoji_only, [7:2] zero
);
   import uetc_pkg::*;

   logic      valid_ff, valid_in;
   flags_type flags_ff, flags_in;

   assign rsp_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      flags_in = flags_ff;
      if (ctl.load) begin
         valid_in = 1'b1;
         flags_in = flags;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      flags_ff <= flags_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, flags_ff.emoji_only, flags_ff.has_emoji};

endmodule

// ----- sv/utf16_emoji_text_classifier_top.sv -----
// UTF-16 emoji text classifier. Code units of a string stream in on the req_ channel,
// one per beat, with req_tlast on the final unit; surrogate pairs are joined, an unpaired
// surrogate counts as a code point of its own, and a zero code point ends the scan of that
// string. One registered result beat per string appears on rsp_ after its last unit is
// accepted: has_emoji and emoji_only (emoji_only ignores skin tones, joiners and variation
// selectors). The block takes one code unit per cycle; the rate is set by the single scan
// step between the input register and the result register, which only waits when a
// finished result stays untaken while the next string's last unit is already held.
module utf16_emoji_text_classifier_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [15:0] code_unit
   input  logic        req_tlast,    // last_unit
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata     // [0] has_emoji, [1] emoji_only, [7:2] zero
);
   import uetc_pkg::*;

   unit_beat_type beat;
   step_ctl_type  ctl;
   flags_type     flags;
   logic          rsp_free;

   uetc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_free   (rsp_free),
      .beat       (beat),
      .ctl        (ctl)
   );

   uetc_scan u_scan (
      .clock (clock),
      .reset (reset),
      .beat  (beat),
      .ctl   (ctl),
      .flags (flags)
   );

   uetc_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .flags      (flags),
      .rsp_free   (rsp_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- sv/uetc_checker.sv -----
module uetc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // emoji only implies some emoji was seen
   a_only_implies_any: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[1] || rsp_tdata[0]))
      else $error("emoji_only set without has_emoji");

   // padding bits of the result stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:2] == 6'd0))
      else $error("result padding not zero");

   // no result is shown right after reset
   a_quiet_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // input side is open right after reset
   a_ready_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_tready)
      else $error("input not ready right after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result beat changed");

endmodule

bind utf16_emoji_text_classifier_top uetc_checker u_uetc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import uetc_pkg::*;

   localparam int RESULT_LATENCY = 2;
   localparam logic [15:0] READY_PATTERN = 16'b1011_0010_1110_0101;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_RANDOM,
      RX_PATTERN
   } rx_mode_type;

   // DUT ports, the driven ones known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [15:0] code_unit
   logic        req_tlast = 1'b0;  // last_unit
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [0] has_emoji, [1] emoji_only, [7:2] zero

   utf16_emoji_text_classifier_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // scan state of the predictor
   bit          lead_held;
   logic [9:0]  held_bits;
   bit          saw_emoji;
   bit          saw_counted;
   bit          saw_other;
   bit          scan_done;

   flags_type   expected_flags[$];
   logic [15:0] text_units[$];

   int          fail_count;
   int          units_sent;
   int          strings_sent;
   int          results_seen;
   int          has_emoji_count;
   int          emoji_only_count;
   bit          tx_gaps;
   int          burst_left;
   rx_mode_type rx_mode = RX_ALWAYS;
   logic        rx_hold = 1'b0;
   logic [3:0]  rx_phase = '0;
   event        hold_go;

   // code points next to each range limit but the one above 1F1FF
   int unsigned range_bounds [35] = '{
      32'h1F2FF, 32'h1F300, 32'h1F5FF, 32'h1F600, 32'h1F64F, 32'h1F650, 32'h1F67F,
      32'h1F680, 32'h1F6FF, 32'h1F700, 32'h1F8FF, 32'h1F900, 32'h1F9FF, 32'h1FA00,
      32'h1FA6F, 32'h1FA70, 32'h1FAFF, 32'h1FB00, 32'h025FF, 32'h02600, 32'h027BF,
      32'h027C0, 32'h1F1E5, 32'h1F1E6, 32'h1F1FF, 32'h1F3FA, 32'h1F3FB, 32'h1F3FF,
      32'h1F400, 32'h0FE0D, 32'h0FE10, 32'h0200C, 32'h0200E, 32'h10000, 32'h10FFFF
   };

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------
   function automatic bit cp_is_emoji(input int unsigned cp);
      return (cp >= 32'h1F300 && cp <= 32'h1F64F) ||
             (cp >= 32'h1F680 && cp <= 32'h1F6FF) ||
             (cp >= 32'h1F900 && cp <= 32'h1F9FF) ||
             (cp >= 32'h1FA70 && cp <= 32'h1FAFF) ||
             (cp >= 32'h02600 && cp <= 32'h027BF) ||
             (cp >= 32'h1F1E6 && cp <= 32'h1F1FF);
   endfunction

   function automatic bit cp_is_ignorable(input int unsigned cp);
      return cp == 32'hFE0F || cp == 32'hFE0E || cp == 32'h200D ||
             (cp >= 32'h1F3FB && cp <= 32'h1F3FF);
   endfunction

   task automatic scan_code_point(input int unsigned cp);
      if (!scan_done) begin
         if (cp == 0) begin
            scan_done = 1'b1;
         end else begin
            if (cp_is_emoji(cp)) saw_emoji = 1'b1;
            if (!cp_is_ignorable(cp)) begin
               if (cp_is_emoji(cp)) saw_counted = 1'b1;
               else saw_other = 1'b1;
            end
         end
      end
   endtask

   task automatic predict_flags(input logic [15:0] unit, input logic last);
      bit        paired;
      flags_type flags;
      paired = 1'b0;
      if (!scan_done) begin
         if (lead_held) begin
            lead_held = 1'b0;
            if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
               scan_code_point((int'(held_bits) << 10) + int'(unit[9:0]) + 32'h10000);
               paired = 1'b1;
            end else begin
               scan_code_point(32'hD800 | int'(held_bits));
            end
         end
         if (!paired) begin
            if (unit >= 16'hD800 && unit <= 16'hDBFF && !last) begin
               lead_held = 1'b1;
               held_bits = unit[9:0];
            end else begin
               scan_code_point(int'(unit));
            end
         end
      end
      if (last) begin
         flags.has_emoji  = saw_emoji;
         flags.emoji_only = saw_counted && !saw_other;
         expected_flags = {expected_flags, flags};
         has_emoji_count  += flags.has_emoji;
         emoji_only_count += flags.emoji_only;
         lead_held   = 1'b0;
         held_bits   = '0;
         saw_emoji   = 1'b0;
         saw_counted = 1'b0;
         saw_other   = 1'b0;
         scan_done   = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------
   // result checker
   // ---------------------------------------------------------------
   always @(posedge clock) begin : check_results
      flags_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_flags.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("error: result beat %h with no string pending", rsp_tdata);
         end else begin
            want = expected_flags.pop_front();
            if (rsp_tdata[0] !== want.has_emoji || rsp_tdata[1] !== want.emoji_only ||
                rsp_tdata[7:2] !== 6'd0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("error: result %0d expected has_emoji=%0b emoji_only=%0b, got %h",
                           results_seen, want.has_emoji, want.emoji_only, rsp_tdata);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // receiver side: stall pattern plus long hold-off
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rx_phase <= rx_phase + 4'd1;
      if (reset || rx_hold) begin
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_ALWAYS:  rsp_tready <= 1'b1;
            RX_RANDOM:  rsp_tready <= ($urandom_range(0, 99) < 60);
            default:    rsp_tready <= READY_PATTERN[rx_phase];
         endcase
      end
   end

   always begin
      @(hold_go);
      rx_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // ---------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------
   task automatic send_unit(input logic [15:0] unit, input logic last);
      if (tx_gaps) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 16);
         end
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tdata  <= unit;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      units_sent++;
      predict_flags(unit, last);
   endtask

   task automatic add_unit(input logic [15:0] unit);
      text_units = {text_units, unit};
   endtask

   // code point to one unit or a surrogate pair
   task automatic add_cp(input int unsigned cp);
      int unsigned off;
      if (cp >= 32'h10000) begin
         off = cp - 32'h10000;
         add_unit(16'hD800 + 16'(off >> 10));
         add_unit(16'hDC00 + 16'(off & 32'h3FF));
      end else begin
         add_unit(cp[15:0]);
      end
   endtask

   task automatic send_text();
      int i;
      for (i = 0; i < text_units.size(); i++)
         send_unit(text_units[i], i == text_units.size() - 1);
      text_units.delete();
      strings_sent++;
   endtask

   task automatic wait_results();
      req_tvalid <= 1'b0;
      while (expected_flags.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 3) @(posedge clock);
   endtask

   function automatic int unsigned emoji_cp();
      case ($urandom_range(0, 6))
         0:       return $urandom_range(32'h1F300, 32'h1F5FF);
         1:       return $urandom_range(32'h1F600, 32'h1F64F);
         2:       return $urandom_range(32'h1F680, 32'h1F6FF);
         3:       return $urandom_range(32'h1F900, 32'h1F9FF);
         4:       return $urandom_range(32'h1FA70, 32'h1FAFF);
         5:       return $urandom_range(32'h02600, 32'h027BF);
         default: return $urandom_range(32'h1F1E6, 32'h1F1FF);
      endcase
   endfunction

   function automatic int unsigned modifier_cp();
      case ($urandom_range(0, 3))
         0:       return 32'hFE0F;
         1:       return 32'hFE0E;
         2:       return 32'h200D;
         default: return $urandom_range(32'h1F3FB, 32'h1F3FF);
      endcase
   endfunction

   // emoji sequences, with modifiers and a little noise
   task automatic build_emoji_text(input int len);
      int k;
      for (k = 0; k < len; k++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: add_cp(emoji_cp());
            11, 12, 13, 14, 15:                add_cp(modifier_cp());
            16:                                add_unit(16'h0000);
            17:                                add_cp(range_bounds[$urandom_range(0, 34)]);
            default:                           add_unit(16'($urandom_range(16'h20, 16'h7E)));
         endcase
      end
   endtask

   // anything the fields allow
   task automatic build_noise_text(input int len);
      int k;
      for (k = 0; k < len; k++) begin
         case ($urandom_range(0, 9))
            0: add_cp(emoji_cp());
            1: add_cp(modifier_cp());
            2: add_cp(range_bounds[$urandom_range(0, 34)]);
            3: add_unit(16'($urandom_range(16'h20, 16'h7E)));
            4: add_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
            5: add_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
            6: add_cp($urandom_range(32'h10000, 32'h10FFFF));
            7: add_unit(($urandom_range(0, 15) == 0) ? 16'h0000 : 16'hFFFF);
            default: add_unit(16'($urandom_range(0, 16'hFFFF)));
         endcase
      end
   endtask

   function automatic int text_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
   endfunction

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------
   task automatic test_directed();
      tx_gaps = 1'b0;
      rx_mode <= RX_ALWAYS;
      add_unit(16'h0041);                                           send_text();
      add_unit(16'h0000);                                           send_text();
      add_unit(16'hD83D); add_unit(16'hDE00);                       send_text();
      add_cp(32'h1F600); add_cp(32'hFE0F); add_cp(32'h200D);
      add_cp(32'h2764);                                             send_text();
      add_cp(32'h1F3FB);                                            send_text();
      add_cp(32'h1F680); add_unit(16'h0061);                        send_text();
      // lead surrogate as final unit, alone and after a held lead
      add_unit(16'hDBFF);                                           send_text();
      add_unit(16'hD83D); add_unit(16'hD83D);                       send_text();
      // held lead broken by a plain unit, then by another lead
      add_unit(16'hD83D); add_unit(16'h2600);                       send_text();
      add_unit(16'hD800); add_unit(16'hD83D); add_unit(16'hDE00);   send_text();
      // lone trail
      add_unit(16'hDC00); add_unit(16'h27BF);                       send_text();
      // zero stops the scan, later units ignored
      add_unit(16'h2600); add_unit(16'h0000); add_unit(16'hFFFF);   send_text();
      add_unit(16'hD83D); add_unit(16'h0000); add_unit(16'h2600);   send_text();
      add_unit(16'hFE0E);                                           send_text();
      add_unit(16'hFFFF); add_unit(16'hDFFF);                       send_text();
      wait_results();
   endtask

   task automatic test_mixed_traffic(input int target);
      int stop_at;
      stop_at = units_sent + target;
      tx_gaps = 1'b1;
      burst_left = 0;
      rx_mode <= RX_RANDOM;
      while (units_sent < stop_at) begin
         if (units_sent > stop_at - target / 2) rx_mode <= RX_PATTERN;
         if ($urandom_range(0, 3) != 0) build_emoji_text(text_length());
         else build_noise_text(text_length());
         send_text();
      end
      wait_results();
   endtask

   task automatic test_back_to_back(input int target);
      int stop_at;
      stop_at = units_sent + target;
      tx_gaps = 1'b0;
      rx_mode <= RX_ALWAYS;
      while (units_sent < stop_at) begin
         if (units_sent > stop_at - target / 2) rx_mode <= RX_PATTERN;
         if ($urandom_range(0, 2) != 0) build_emoji_text(text_length());
         else build_noise_text(text_length());
         send_text();
      end
      wait_results();
   endtask

   // receiver holds off while short strings keep coming, so the input backs up
   task automatic test_output_backpressure(input int target);
      int stop_at;
      stop_at = units_sent + target;
      tx_gaps = 1'b0;
      rx_mode <= RX_ALWAYS;
      -> hold_go;
      while (units_sent < stop_at) begin
         build_emoji_text($urandom_range(1, 3));
         send_text();
      end
      wait_results();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_mixed_traffic(900);
      test_back_to_back(400);
      test_output_backpressure(350);
      wait_results();
      if (expected_flags.size() != 0) fail_count++;
      $display("summary: %0d strings, %0d code units, %0d result beats checked",
               strings_sent, units_sent, results_seen);
      $display("summary: %0d with emoji, %0d emoji only, %0d errors",
               has_emoji_count, emoji_only_count, fail_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
